[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL, included by the message hasher core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[hw/rtl/sha256_pkg.sv]
// Package with SHA-256 types, constants and helper functions.
`default_nettype none
package sha256_pkg;
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD,
        ST_OUT
    } t_state;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;

    function automatic logic [31:0] f_iv(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] f_k(input logic [5:0] r);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[r];
    endfunction
endpackage
`default_nettype wire

[hw/rtl/sha256_round.sv]
// One SHA-256 round and one message schedule step, reused every cycle.
`default_nettype none
module sha256_round
    import sha256_pkg::*;
(
    input  wire logic [255:0] i_vars,
    input  wire logic [31:0]  i_w,
    input  wire logic [5:0]   i_round,
    input  wire logic [31:0]  i_w1,
    input  wire logic [31:0]  i_w9,
    input  wire logic [31:0]  i_w14,
    output logic      [255:0] o_vars,
    output logic      [31:0]  o_w_next
);
    logic [31:0] a, b, c, d, e, f, g, h, s1, ch, t1, s0, mj, sg0, sg1;
    always_comb begin
        {a, b, c, d, e, f, g, h} = i_vars;
        s1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
        ch = (e & f) ^ (~e & g);
        t1 = h + s1 + ch + f_k(i_round) + i_w;
        s0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
        mj = (a & b) ^ (a & c) ^ (b & c);
        o_vars = {t1 + s0 + mj, a, b, c, d + t1, e, f, g};
        sg0 = {i_w1[6:0], i_w1[31:7]} ^ {i_w1[17:0], i_w1[31:18]} ^ {3'b000, i_w1[31:3]};
        sg1 = {i_w14[16:0], i_w14[31:17]} ^ {i_w14[18:0], i_w14[31:19]}
            ^ {10'd0, i_w14[31:10]};
        o_w_next = i_w + sg0 + i_w9 + sg1;
    end
endmodule
`default_nettype wire

[hw/rtl/sha256_message_hasher_core.sv]
// Top level of the byte-serial SHA-256 message hasher.
//   Channel | Direction | Payload
//   in      | input     | t_in_item: msg_byte, byte_valid, end_of_message
//   out     | output    | t_out_item: digest_word, word_index, last_word
// A byte item is taken while input ready is high; the 64th byte of a block
// starts a compression, one round per cycle in a single shared round unit,
// followed by a fold step that adds the result into the chaining value.
// End of message adds one or two padded compressions, each a setup step plus
// the compression and fold, then eight output items, one per cycle unless stalled.
// Input ready is low while compressing, padding or emitting the digest.
// Reset is synchronous and active low; the block buffer is not cleared.
`default_nettype none
`include "assert_macros.svh"
module sha256_message_hasher_core
    import sha256_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data
);
    // Sixteen-word sliding schedule window; word 0 is the current round's word.
    logic [31:0]  r_w [16];
    logic [255:0] r_h, r_v, n_v;
    logic [63:0]  r_cnt;
    logic [5:0]   r_fill, r_round;
    logic [2:0]   r_oidx;
    logic         r_final;   // compression in flight belongs to message end
    logic         r_padded;  // the padding block has been set up
    logic         r_second;  // a length-only block follows
    logic         r_fold;    // last round done, add into chaining value
    t_state       r_state, n_state;
    logic [31:0]  w_next;
    logic         acc;
    logic [6:0]   fill1;
    logic         pad_two;
    logic [31:0]  pad_w [16];

    sha256_round u_round (
        .i_vars(r_v), .i_w(r_w[0]), .i_round(r_round),
        .i_w1(r_w[1]), .i_w9(r_w[9]), .i_w14(r_w[14]),
        .o_vars(n_v), .o_w_next(w_next)
    );

    assign acc = i_valid && o_ready;
    assign fill1 = {1'b0, r_fill} + {6'd0, i_data.byte_valid};
    assign o_data.digest_word = r_h[255 - 32 * r_oidx -: 32];
    assign o_data.word_index = r_oidx;
    assign o_data.last_word = (r_oidx == 3'd7);

    // The sequencer: a full block compresses at once; at message end a data
    // block still in flight is followed by the padding block, and a padding
    // block with no room for the length is followed by a length-only block.
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (fill1[6]) begin
                        n_state = ST_COMP;
                    end else if (i_data.end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                n_state = ST_COMP;
            end
            ST_COMP: begin
                if (r_fold) begin
                    if (!r_final) begin
                        n_state = ST_IDLE;
                    end else if (!r_padded || r_second) begin
                        n_state = ST_PAD;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready && (r_oidx == 3'd7)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Padded window: the mark at the fill position, zeros after it, and the
    // bit count in the last two words when there is room. A length-only
    // block is all zeros apart from the bit count.
    always_comb begin
        pad_two = (r_fill >= LENGTH_POS);
        for (int k = 0; k < 16; k++) begin
            pad_w[k] = r_w[k];
            for (int j = 0; j < 4; j++) begin
                if (r_second || (6'(4 * k + j) > r_fill))
                    pad_w[k][31 - 8 * j -: 8] = 8'h00;
                else if (6'(4 * k + j) == r_fill)
                    pad_w[k][31 - 8 * j -: 8] = PAD_MARK;
            end
        end
        if (r_second || !pad_two) begin
            pad_w[14] = r_cnt[63:32];
            pad_w[15] = r_cnt[31:0];
        end
    end

    // Byte write into the window, word-aligned big-endian.
    function automatic logic [31:0] f_put(input logic [31:0] w, input logic [1:0] p,
                                          input logic [7:0] b);
        logic [31:0] t;
        t = w;
        t[31 - 8 * p -: 8] = b;
        return t;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_h <= {f_iv(3'd0), f_iv(3'd1), f_iv(3'd2), f_iv(3'd3),
                    f_iv(3'd4), f_iv(3'd5), f_iv(3'd6), f_iv(3'd7)};
            r_cnt <= '0;
            r_fill <= '0;
            r_round <= '0;
            r_oidx <= '0;
            r_final <= 1'b0;
            r_padded <= 1'b0;
            r_second <= 1'b0;
            r_fold <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        if (i_data.byte_valid) begin
                            r_w[r_fill[5:2]] <= f_put(r_w[r_fill[5:2]], r_fill[1:0],
                                                      i_data.msg_byte);
                            r_cnt <= r_cnt + 64'd8;
                        end
                        r_fill <= fill1[5:0];
                        r_final <= i_data.end_of_message;
                        r_padded <= 1'b0;
                        r_second <= 1'b0;
                        r_v <= r_h; r_round <= '0; r_fold <= 1'b0;
                    end
                end
                ST_PAD: begin
                    for (int k = 0; k < 16; k++) r_w[k] <= pad_w[k];
                    r_second <= !r_second && pad_two;
                    r_padded <= 1'b1;
                    r_v <= r_h; r_round <= '0; r_fold <= 1'b0;
                end
                ST_COMP: begin
                    if (r_fold) begin
                        for (int k = 0; k < 8; k++)
                            r_h[255 - 32 * k -: 32] <= r_h[255 - 32 * k -: 32]
                                                     + r_v[255 - 32 * k -: 32];
                        r_fold <= 1'b0;
                        r_fill <= '0;
                        r_oidx <= '0;
                    end else begin
                        r_v <= n_v;
                        for (int k = 0; k < 15; k++) r_w[k] <= r_w[k + 1];
                        r_w[15] <= w_next;
                        r_round <= r_round + 6'd1;
                        if (r_round == 6'd63) r_fold <= 1'b1;
                    end
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_h <= {f_iv(3'd0), f_iv(3'd1), f_iv(3'd2), f_iv(3'd3),
                                    f_iv(3'd4), f_iv(3'd5), f_iv(3'd6), f_iv(3'd7)};
                            r_cnt <= '0; r_fill <= '0; r_final <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    `ASSERT_NEVER(a_no_out_idle, i_clk, i_rst_n, o_valid && o_ready, "ready while emitting")
    `ASSERT_IMPL(a_last_wraps, i_clk, i_rst_n, (o_valid && i_ready && o_data.last_word) |=> o_ready, "no idle after digest")
    `ASSERT_IMPL(a_round_bound, i_clk, i_rst_n, r_fold |-> (r_round == 6'd0), "fold off round end")
endmodule
`default_nettype wire

[dv/tb_sha256_message_hasher_core.sv]
// Testbench for the byte-serial SHA-256 message hasher core.
`default_nettype none
module tb_sha256_message_hasher_core;
    import sha256_pkg::*;

    // Standard SHA-256 constants, kept locally so the hash predictor stands on its own.
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    localparam logic [31:0] START_H [8] = '{
        32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
        32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;

    sha256_message_hasher_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // Predictor state: chaining value, bit count and the partial block.
    logic [31:0] hash_h [8];
    logic [63:0] bit_count;
    logic [7:0]  blk [64];
    int unsigned blk_fill;

    t_in_item  byte_items [$];
    t_out_item digest_words [$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        error_count;
    int        cycle_count;
    logic      o_ready_at_edge;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_blk();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        for (int r = 16; r < 64; r++) begin
            s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
            s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
            w[r] = w[r-16] + s0 + w[r-7] + s1;
        end
        {a, b, c, d, e, f, g, h} = {hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                                    hash_h[4], hash_h[5], hash_h[6], hash_h[7]};
        for (int r = 0; r < 64; r++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[r] + w[r];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
        hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) hash_h[i] = START_H[i];
        bit_count = '0;
        blk_fill = 0;
    endtask

    // Advances the predictor by one accepted item and queues any digest it finishes.
    task automatic hash_item(input t_in_item it);
        t_out_item dw;
        if (it.byte_valid) begin
            blk[blk_fill] = it.msg_byte;
            blk_fill++;
            bit_count += 64'd8;
            if (blk_fill == 64) begin
                compress_blk();
                blk_fill = 0;
            end
        end
        if (it.end_of_message) begin
            blk[blk_fill] = PAD_MARK;
            blk_fill++;
            if (blk_fill > LENGTH_POS) begin
                while (blk_fill < 64) begin
                    blk[blk_fill] = 8'h00;
                    blk_fill++;
                end
                compress_blk();
                blk_fill = 0;
            end
            while (blk_fill < LENGTH_POS) begin
                blk[blk_fill] = 8'h00;
                blk_fill++;
            end
            for (int i = 0; i < 8; i++) blk[63-i] = bit_count[8*i +: 8];
            compress_blk();
            for (int i = 0; i < 8; i++) begin
                dw.digest_word = hash_h[i];
                dw.word_index  = 3'(i);
                dw.last_word   = (i == 7);
                digest_words.push_back(dw);
            end
            restart_hash();
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic add_item(input logic [7:0] b, input logic bv, input logic eom);
        t_in_item it;
        it.msg_byte = b;
        it.byte_valid = bv;
        it.end_of_message = eom;
        byte_items.push_back(it);
    endtask

    // Queues one message of random bytes; the final byte may ride with the end mark.
    task automatic add_message(input int len);
        bit merged;
        merged = (len > 0) && ($urandom_range(1) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) add_item(8'($urandom), 1'b0, 1'b0);
            add_item(8'($urandom), 1'b1, merged && (i == len - 1));
        end
        if (!merged) add_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        while (byte_items.size() != 0 || digest_words.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    always #5 i_clk = ~i_clk;

    // Driver: presents items at the falling edge and holds them until accepted.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready_at_edge) begin
                void'(byte_items.pop_front());
            end
            if (i_valid && !o_ready_at_edge) begin
                i_valid <= 1'b1;
            end else if (byte_items.size() != 0 &&
                         !($urandom_range(99) < send_idle_pct)) begin
                i_valid <= 1'b1;
                i_data  <= byte_items[0];
            end else begin
                i_valid <= 1'b0;
            end
            i_ready <= !($urandom_range(99) < recv_stall_pct);
        end
    end

    // Records the input handshake at the rising edge for the driver and predictor.
    always @(posedge i_clk) begin
        o_ready_at_edge <= 1'b0;
        if (i_rst_n && i_valid && o_ready) begin
            o_ready_at_edge <= 1'b1;
            hash_item(i_data);
        end
    end

    // Monitor: compares every accepted output item with the oldest expected word.
    always @(posedge i_clk) begin
        t_out_item want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (digest_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", o_data.digest_word));
            end else begin
                want = digest_words.pop_front();
                if (o_data.digest_word !== want.digest_word)
                    report_mismatch($sformatf("word %0d: got %h want %h", want.word_index,
                                              o_data.digest_word, want.digest_word));
                if (o_data.word_index !== want.word_index)
                    report_mismatch($sformatf("index: got %0d want %0d",
                                              o_data.word_index, want.word_index));
                if (o_data.last_word !== want.last_word)
                    report_mismatch($sformatf("last flag: got %0b want %0b",
                                              o_data.last_word, want.last_word));
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            report_mismatch("cycle limit reached");
            $display("tb_sha256_message_hasher_core: errors");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data = '0;
        o_ready_at_edge = 1'b0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 64; i++) blk[i] = 8'h00;
        restart_hash();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty items, an empty message, "abc" and byte extremes.
        add_item(8'hff, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b1);
        add_item("a", 1'b1, 1'b0);
        add_item("b", 1'b1, 1'b0);
        add_item("c", 1'b1, 1'b1);
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'hff, 1'b1, 1'b0);
        add_item(8'h55, 1'b0, 1'b0);
        add_item(8'haa, 1'b1, 1'b1);
        wait_drained();

        // Per flow-control phase: a 56-byte message that needs a
        // length-only block, a full 64-byte block whose last byte carries the
        // end mark, then two short random messages in each of the last two phases.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 53 : (ph == 3) ? 30 : 0;
            recv_stall_pct = (ph == 2) ? 53 : (ph == 3) ? 30 : 0;
            case (ph)
                0: add_message(56);
                1: begin
                    for (int i = 0; i < 64; i++) add_item(8'($urandom), 1'b1, i == 63);
                end
                default: begin
                    add_message($urandom_range(0, 12));
                    add_message($urandom_range(0, 12));
                end
            endcase
            wait_drained();
        end

        if (error_count == 0) begin
            $display("tb_sha256_message_hasher_core: clean");
        end else begin
            $display("tb_sha256_message_hasher_core: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
